// ===== rtl/pbd_pkg.sv =====
// ----------------------------------------------------------------------------
// Pulse beat detector package
// Shared types, sequencer states and filter constants.
// ----------------------------------------------------------------------------
package pbd_pkg;

   localparam int TapTotal  = 23;  // taps in the symmetric FIR
   localparam int HalfTaps  = 11;  // folded pairs
   localparam int CenterTap = 11;  // unpaired middle tap

   localparam int SampleWidth = 16;
   localparam int AccWidth    = 32;
   localparam int CoefWidth   = 13;
   localparam int ProdWidth   = 30;

   // register word indices (address bit 2)
   localparam logic REG_MIN_SWING = 1'b0;
   localparam logic REG_MAX_SWING = 1'b1;

   localparam logic [15:0] MIN_SWING_RESET = 16'd20;
   localparam logic [15:0] MAX_SWING_RESET = 16'd1000;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIFF,
      ST_ACC,
      ST_SHIFT,
      ST_MAC,
      ST_SUM,
      ST_FINISH
   } state_type;

   // control for the tap cells
   typedef struct packed {
      logic shift;   // take a new sample, every cell passes one place on
      logic rotate;  // turn the two halves of the row one place
   } tap_ctrl_type;

   // control for the multiply-accumulate unit
   typedef struct packed {
      logic       mult;   // register pair * coefficient
      logic       load;   // start the sum from the centre tap
      logic       accum;  // add the registered product
      logic [3:0] idx;    // coefficient index
   } mac_ctrl_type;

   // Q15 low-pass coefficients of the outer pairs, the centre weight last
   function automatic logic [CoefWidth-1:0] fir_coef(input logic [3:0] idx);
      logic [CoefWidth-1:0] c;
      case (idx)
         4'd0:    c = 13'd172;
         4'd1:    c = 13'd321;
         4'd2:    c = 13'd579;
         4'd3:    c = 13'd927;
         4'd4:    c = 13'd1360;
         4'd5:    c = 13'd1858;
         4'd6:    c = 13'd2390;
         4'd7:    c = 13'd2916;
         4'd8:    c = 13'd3391;
         4'd9:    c = 13'd3768;
         4'd10:   c = 13'd4012;
         4'd11:   c = 13'd4096;
         default: c = '0;
      endcase
      return c;
   endfunction

endpackage

// ===== rtl/pbd_tap_cell.sv =====
// ----------------------------------------------------------------------------
// Tap cell
// One 16-bit delay-line entry; shifts along the row or rotates in its ring.
// ----------------------------------------------------------------------------
module pbd_tap_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  pbd_pkg::tap_ctrl_type ctrl,
   input  logic [15:0]           shift_din,
   input  logic [15:0]           rot_din,
   output logic [15:0]           dout
);

   logic [15:0] tap_ff;
   logic [15:0] tap_in;

   always_comb begin
      tap_in = tap_ff;
      if (ctrl.shift) begin
         tap_in = shift_din;
      end else if (ctrl.rotate) begin
         tap_in = rot_din;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_ff <= '0;
      end else begin
         tap_ff <= tap_in;
      end
   end

   assign dout = tap_ff;

endmodule

// ===== rtl/pbd_tap_chain.sv =====
// ----------------------------------------------------------------------------
// Tap chain
// Row of tap cells holding the last 23 AC samples, newest in cell 0.
// ----------------------------------------------------------------------------
module pbd_tap_chain (
   input  logic                  clock,
   input  logic                  reset,
   input  pbd_pkg::tap_ctrl_type ctrl,
   input  logic [15:0]           din,
   output logic [15:0]           front_head,
   output logic [15:0]           back_head,
   output logic [15:0]           center
);

   localparam int Last = pbd_pkg::TapTotal - 1;
   localparam int Mid  = pbd_pkg::CenterTap;

   logic [15:0] tap_q [pbd_pkg::TapTotal];

   // Front half rotates towards cell 0, back half towards the last cell,
   // so the two heads meet each pair in turn; the centre cell holds.
   for (genvar k = 0; k < pbd_pkg::TapTotal; k++) begin : g_cell
      logic [15:0] shift_src;
      logic [15:0] rot_src;

      if (k == 0) begin : g_first
         assign shift_src = din;
      end else begin : g_next
         assign shift_src = tap_q[k-1];
      end

      if (k < Mid - 1) begin : g_front
         assign rot_src = tap_q[k+1];
      end else if (k == Mid - 1) begin : g_front_end
         assign rot_src = tap_q[0];
      end else if (k == Mid) begin : g_mid
         assign rot_src = tap_q[Mid];
      end else if (k == Mid + 1) begin : g_back_start
         assign rot_src = tap_q[Last];
      end else begin : g_back
         assign rot_src = tap_q[k-1];
      end

      pbd_tap_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .shift_din (shift_src),
         .rot_din   (rot_src),
         .dout      (tap_q[k])
      );
   end

   assign front_head = tap_q[0];
   assign back_head  = tap_q[Last];
   assign center     = tap_q[Mid];

endmodule

// ===== rtl/pbd_fir_mac.sv =====
// ----------------------------------------------------------------------------
// FIR multiply-accumulate
// One folded pair per cycle: wrap the pair sum, multiply, then accumulate.
// ----------------------------------------------------------------------------
module pbd_fir_mac (
   input  logic                  clock,
   input  pbd_pkg::mac_ctrl_type ctrl,
   input  logic [15:0]           front,
   input  logic [15:0]           back,
   input  logic [15:0]           center,
   output logic [31:0]           z
);

   logic [15:0]                  pair;
   logic signed [15:0]           pair_s;
   logic signed [13:0]           coef_s;
   logic signed [29:0]           prod_in;
   logic signed [29:0]           prod_ff;
   logic [31:0]                  z_ff;
   logic [31:0]                  z_in;
   logic [31:0]                  center_term;

   assign pair        = front + back;
   assign pair_s      = signed'(pair);
   assign coef_s      = signed'({1'b0, pbd_pkg::fir_coef(ctrl.idx)});
   assign prod_in     = pair_s * coef_s;
   // centre weight is 4096: a shift by twelve
   assign center_term = {{4{center[15]}}, center, 12'b0};

   always_comb begin
      z_in = z_ff;
      if (ctrl.load) begin
         z_in = center_term;
      end else if (ctrl.accum) begin
         z_in = z_ff + {{2{prod_ff[29]}}, prod_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.mult) begin
         prod_ff <= prod_in;
      end
      z_ff <= z_in;
   end

   assign z = z_ff;

endmodule

// ===== rtl/pulse_beat_detector.sv =====
// ----------------------------------------------------------------------------
// Pulse beat detector
// DC removal, 23-tap low-pass FIR on a rotating tap row, beat detection.
// ----------------------------------------------------------------------------
//  Channel | Direction | Contents
//  req_    | in        | tdata[17:0] sample
//  rsp_    | out       | tdata[0] beat, [16:1] ac_value, [32:17] dc_level
//  csr_    | in/out    | 0x0 min_swing, 0x4 max_swing (low 16 bits)
//
//  Steps from one transfer to the next: accept, DC difference, DC
//  accumulator update, shift into the tap row, eleven pair products on
//  the rotating row, final sum, result load. req_tready is high only in
//  the idle state, so a new sample waits until the item is done. The
//  pair products all share the single multiplier.
//  Reset clears tap row, DC accumulator and edge tracking, presets registers.
//  A result held by rsp_tready low stalls only the final load; the next
//  sample is still taken while a result waits.
// ----------------------------------------------------------------------------
module pulse_beat_detector (
   input  logic        clock,
   input  logic        reset,
   // input stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [17:0] sample, [23:18] zero
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [0] beat, [16:1] ac_value, [32:17] dc_level
   // register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   // ---------------------------------------------------------------- control
   pbd_pkg::state_type     state_ff, state_in;
   logic [3:0]             cnt_ff, cnt_in;
   pbd_pkg::tap_ctrl_type  tap_ctrl;
   pbd_pkg::mac_ctrl_type  mac_ctrl;

   logic req_xfer;
   logic out_free;
   logic out_load;

   // ---------------------------------------------------------------- datapath
   logic [15:0] sample_ff, sample_in;
   logic [31:0] acc_ff, acc_in;
   logic [31:0] diff_ff, diff_in;
   logic [15:0] dc_ff, dc_in;
   logic [15:0] din;

   logic [15:0] front_head, back_head, center;
   logic [31:0] z;

   // edge tracking
   logic [15:0] last_ac_ff, last_ac_in;
   logic [15:0] run_peak_ff, run_peak_in;
   logic [15:0] run_trough_ff, run_trough_in;
   logic        rising_ff, rising_in;
   logic        falling_ff, falling_in;

   logic signed [15:0] cur_s, prev_s;
   logic               rise, fall;
   logic signed [17:0] swing;
   logic               beat;
   logic [15:0]        peak_base, trough_base;

   // registers and result
   logic [15:0] min_swing_ff, min_swing_in;
   logic [15:0] max_swing_ff, max_swing_in;
   logic        csr_write;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        beat_ff;
   logic [15:0] ac_out_ff;
   logic [15:0] dc_out_ff;

   assign req_xfer = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign out_load = (state_ff == pbd_pkg::ST_FINISH) && out_free;

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         pbd_pkg::ST_IDLE: begin
            if (req_xfer) begin
               state_in = pbd_pkg::ST_DIFF;
            end
         end
         pbd_pkg::ST_DIFF:  state_in = pbd_pkg::ST_ACC;
         pbd_pkg::ST_ACC:   state_in = pbd_pkg::ST_SHIFT;
         pbd_pkg::ST_SHIFT: begin
            state_in = pbd_pkg::ST_MAC;
            cnt_in   = '0;
         end
         pbd_pkg::ST_MAC: begin
            // step through the outer pairs, one per cycle
            if (cnt_ff == 4'(pbd_pkg::HalfTaps - 1)) begin
               state_in = pbd_pkg::ST_SUM;
            end else begin
               cnt_in = cnt_ff + 4'd1;
            end
         end
         pbd_pkg::ST_SUM:   state_in = pbd_pkg::ST_FINISH;
         pbd_pkg::ST_FINISH: begin
            // hold here while the previous result is still waiting
            if (out_free) begin
               state_in = pbd_pkg::ST_IDLE;
            end
         end
         default:           state_in = pbd_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready      = 1'b0;
      tap_ctrl.shift  = 1'b0;
      tap_ctrl.rotate = 1'b0;
      mac_ctrl.mult   = 1'b0;
      mac_ctrl.load   = 1'b0;
      mac_ctrl.accum  = 1'b0;
      mac_ctrl.idx    = cnt_ff;
      case (state_ff)
         pbd_pkg::ST_IDLE:  req_tready = 1'b1;
         pbd_pkg::ST_SHIFT: tap_ctrl.shift = 1'b1;
         pbd_pkg::ST_MAC: begin
            tap_ctrl.rotate = 1'b1;
            mac_ctrl.mult   = 1'b1;
            // first step seeds the sum with the centre tap
            mac_ctrl.load   = (cnt_ff == '0);
            mac_ctrl.accum  = (cnt_ff != '0);
         end
         pbd_pkg::ST_SUM:   mac_ctrl.accum = 1'b1;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pbd_pkg::ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // ---------------------------------------------------------------- DC tracker
   // acc += ((low16 << 15) - acc) >>> 4, difference and update in separate states
   always_comb begin
      sample_in = sample_ff;
      diff_in   = diff_ff;
      acc_in    = acc_ff;
      dc_in     = dc_ff;
      if (req_xfer) begin
         sample_in = req_tdata[15:0];
      end
      if (state_ff == pbd_pkg::ST_DIFF) begin
         diff_in = {1'b0, sample_ff, 15'b0} - acc_ff;
      end
      if (state_ff == pbd_pkg::ST_ACC) begin
         acc_in = acc_ff + {{4{diff_ff[31]}}, diff_ff[31:4]};
      end
      if (state_ff == pbd_pkg::ST_SHIFT) begin
         dc_in = acc_ff[30:15];
      end
   end

   // AC sample into the tap row: sample minus DC level, wrapped
   assign din = sample_ff - acc_ff[30:15];

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
      sample_ff <= sample_in;
      diff_ff   <= diff_in;
      dc_ff     <= dc_in;
   end

   // ---------------------------------------------------------------- FIR
   pbd_tap_chain u_chain (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (tap_ctrl),
      .din        (din),
      .front_head (front_head),
      .back_head  (back_head),
      .center     (center)
   );

   pbd_fir_mac u_mac (
      .clock  (clock),
      .ctrl   (mac_ctrl),
      .front  (front_head),
      .back   (back_head),
      .center (center),
      .z      (z)
   );

   // ---------------------------------------------------------------- edges
   // filtered output is z >>> 15 wrapped to 16 bits
   assign cur_s  = signed'(z[30:15]);
   assign prev_s = signed'(last_ac_ff);
   assign rise   = (prev_s < 0) && (cur_s >= 0);
   assign fall   = (prev_s > 0) && (cur_s <= 0);

   // on a rising crossing the swing is the running peak minus the running trough
   assign swing = signed'({{2{run_peak_ff[15]}}, run_peak_ff})
                - signed'({{2{run_trough_ff[15]}}, run_trough_ff});
   assign beat  = rise && (swing > signed'({2'b00, min_swing_ff}))
                       && (swing < signed'({2'b00, max_swing_ff}));

   always_comb begin
      last_ac_in    = last_ac_ff;
      rising_in     = rising_ff;
      falling_in    = falling_ff;
      run_peak_in   = run_peak_ff;
      run_trough_in = run_trough_ff;
      peak_base     = rise ? 16'd0 : run_peak_ff;
      trough_base   = fall ? 16'd0 : run_trough_ff;
      if (out_load) begin
         last_ac_in    = z[30:15];
         rising_in     = rise ? 1'b1 : (fall ? 1'b0 : rising_ff);
         falling_in    = fall ? 1'b1 : (rise ? 1'b0 : falling_ff);
         run_peak_in   = (rising_in && (cur_s > prev_s)) ? z[30:15] : peak_base;
         run_trough_in = (falling_in && (cur_s < prev_s)) ? z[30:15] : trough_base;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ac_ff    <= '0;
         rising_ff     <= 1'b0;
         falling_ff    <= 1'b0;
         run_peak_ff   <= '0;
         run_trough_ff <= '0;
      end else begin
         last_ac_ff    <= last_ac_in;
         rising_ff     <= rising_in;
         falling_ff    <= falling_in;
         run_peak_ff   <= run_peak_in;
         run_trough_ff <= run_trough_in;
      end
   end

   // ---------------------------------------------------------------- result
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (out_load) begin
         beat_ff   <= beat;
         ac_out_ff <= z[30:15];
         dc_out_ff <= dc_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, dc_out_ff, ac_out_ff, beat_ff};

   // ---------------------------------------------------------------- registers
   // word index in address bit 2; only the low 16 data bits are kept
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      min_swing_in = min_swing_ff;
      max_swing_in = max_swing_ff;
      if (csr_write) begin
         case (csr_paddr[2])
            pbd_pkg::REG_MIN_SWING: min_swing_in = csr_pwdata[15:0];
            pbd_pkg::REG_MAX_SWING: max_swing_in = csr_pwdata[15:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_swing_ff <= pbd_pkg::MIN_SWING_RESET;
         max_swing_ff <= pbd_pkg::MAX_SWING_RESET;
      end else begin
         min_swing_ff <= min_swing_in;
         max_swing_ff <= max_swing_in;
      end
   end

   always_comb begin
      case (csr_paddr[2])
         pbd_pkg::REG_MIN_SWING: csr_prdata = {16'b0, min_swing_ff};
         pbd_pkg::REG_MAX_SWING: csr_prdata = {16'b0, max_swing_ff};
         default:                csr_prdata = '0;
      endcase
   end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Pulse beat detector testbench
// Drives raw samples into the detector and checks every beat flag, filtered AC
// value and DC level against an in-bench estimator of the DC tracker, the
// folded 23-tap FIR and the zero-crossing edge tracker. A short directed table
// comes first, then random traffic, mostly pulses, under several swing limits.
// ----------------------------------------------------------------------------
module testbench;

   localparam int WatchdogLimit = 1000;  // cycles without any stream transfer
   localparam int SettleCycles  = 34;    // extra wait once every result is back
   localparam int PhaseTotal    = 6;
   localparam int PhaseItems    = 125;

   // Q15 weights of the outer pairs, centre weight last
   localparam int FirWeight [12] = '{172, 321, 579, 927, 1360, 1858,
                                     2390, 2916, 3391, 3768, 4012, 4096};

   typedef struct packed {
      logic               beat;
      logic signed [15:0] ac_value;
      logic signed [15:0] dc_level;
   } beat_result_type;

   typedef struct packed {
      logic [17:0]     raw;
      logic            typed;   // expectation typed in below, else estimated
      beat_result_type result;
   } stim_row_type;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata   = '0;   // [17:0] sample, [23:18] zero
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [39:0] rsp_tdata;          // [0] beat, [16:1] ac_value, [32:17] dc_level
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [2:0]  csr_paddr   = '0;
   logic [31:0] csr_pwdata  = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   pulse_beat_detector dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Estimator state: a private copy of everything the detector remembers
   // ------------------------------------------------------------------------
   logic signed [31:0] est_dc_acc;
   logic signed [15:0] est_taps [32];
   logic [4:0]         est_slot;
   logic signed [15:0] est_prev_ac;
   logic signed [15:0] est_peak_latched;
   logic signed [15:0] est_trough_latched;
   logic signed [15:0] est_peak_run;
   logic signed [15:0] est_trough_run;
   logic               est_rising;
   logic               est_falling;
   int                 est_min_swing;
   int                 est_max_swing;

   beat_result_type pending_results [$];   // one expectation per accepted sample
   int           error_count = 0;
   int           gap_pct     = 0;       // chance of a sender gap before a sample
   int           stall_pct   = 0;       // chance of a receiver stall burst
   bit           calm        = 1'b0;    // no idling at all in the closing stretch
   int           stall_left  = 0;
   int           idle_cycles = 0;

   stim_row_type directed_rows [24] = '{
      // straight after reset everything is zero
      '{18'h00000, 1'b1, '{1'b0, 16'sh0000, 16'sh0000}},
      // full-scale step: DC moves by one sixteenth, first tap sees -4096
      '{18'h3FFFF, 1'b1, '{1'b0, 16'shFFEA, 16'sh0FFF}},
      '{18'h00000, 1'b0, '0},
      '{18'h0FFFF, 1'b0, '0},
      // upper sample bits alone must change nothing
      '{18'h10000, 1'b0, '0},
      '{18'h20000, 1'b0, '0},
      '{18'h30000, 1'b0, '0},
      '{18'h3FFFF, 1'b0, '0},
      '{18'h08000, 1'b0, '0},
      '{18'h07FFF, 1'b0, '0},
      '{18'h18000, 1'b0, '0},
      '{18'h27FFF, 1'b0, '0},
      '{18'h00001, 1'b0, '0},
      '{18'h0FFFE, 1'b0, '0},
      '{18'h2AAAA, 1'b0, '0},
      '{18'h15555, 1'b0, '0},
      // square wave to force rising and falling zero crossings
      '{18'h09000, 1'b0, '0},
      '{18'h09000, 1'b0, '0},
      '{18'h07000, 1'b0, '0},
      '{18'h07000, 1'b0, '0},
      '{18'h09000, 1'b0, '0},
      '{18'h09000, 1'b0, '0},
      '{18'h07000, 1'b0, '0},
      '{18'h07000, 1'b0, '0}
   };

   function automatic void note_mismatch(input string what, input int want,
                                         input int got);
      $display("%0t ns: %s mismatch, expected %0d, actual %0d",
               $time, what, want, got);
      error_count++;
   endfunction

   // Advance the estimator by one sample and return what the detector owes.
   function automatic beat_result_type predict_beat(input logic [17:0] raw);
      logic [15:0]        low16;
      logic signed [31:0] diff;
      logic signed [15:0] dc;
      logic signed [15:0] din;
      logic signed [15:0] cur;
      logic signed [15:0] pair;
      logic [4:0]         pos;
      int                 z;
      int                 k;
      int                 swing;
      beat_result_type    res;

      // DC tracker: first-order IIR, 32-bit wrap, bits 16 and 17 dropped
      low16      = raw[15:0];
      diff       = {1'b0, low16, 15'd0} - est_dc_acc;
      est_dc_acc = est_dc_acc + (diff >>> 4);
      dc         = est_dc_acc[30:15];
      din        = low16 - dc;

      // folded FIR: pair sums wrap to 16 bits, accumulation to 32
      pos           = est_slot;
      est_taps[pos] = din;
      z = FirWeight[11] * est_taps[pos - 5'd11];
      for (k = 0; k < 11; k++) begin
         pair = est_taps[pos - k[4:0]] + est_taps[pos - 5'd22 + k[4:0]];
         z    = z + FirWeight[k] * pair;
      end
      est_slot = pos + 5'd1;
      cur      = z[30:15];

      res.beat     = 1'b0;
      res.ac_value = cur;
      res.dc_level = dc;

      // rising crossing: latch the extremes and judge the unwrapped swing
      if (est_prev_ac < 0 && cur >= 0) begin
         est_peak_latched   = est_peak_run;
         est_trough_latched = est_trough_run;
         est_rising         = 1'b1;
         est_falling        = 1'b0;
         est_peak_run       = '0;
         swing = int'(est_peak_latched) - int'(est_trough_latched);
         if (swing > est_min_swing && swing < est_max_swing)
            res.beat = 1'b1;
      end
      if (est_prev_ac > 0 && cur <= 0) begin
         est_rising     = 1'b0;
         est_falling    = 1'b1;
         est_trough_run = '0;
      end
      if (est_rising && cur > est_prev_ac)
         est_peak_run = cur;
      if (est_falling && cur < est_prev_ac)
         est_trough_run = cur;
      est_prev_ac = cur;
      return res;
   endfunction

   // Offer one sample, hold it until the transfer, then log the expectation.
   task automatic send_sample(input logic [17:0] raw, input logic typed,
                              input beat_result_type typed_result);
      beat_result_type predicted;
      if (!calm && $urandom_range(99) < gap_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(14, 1)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'd0, raw};
      do @(posedge clock); while (!req_tready);
      predicted = predict_beat(raw);
      // the estimator always advances; a typed row overrides its answer
      pending_results.push_back(typed ? typed_result : predicted);
   endtask

   // Drop valid and wait until the detector has handed back every result.
   task automatic flush_results();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   // One register access: setup cycle, then access until pready.
   task automatic csr_transfer(input logic wr, input logic idx,
                               input logic [31:0] wdata, output logic [31:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // Write both limits with junk in the upper half, then read them back.
   task automatic set_swing_limits(input logic [15:0] lo, input logic [15:0] hi);
      logic [31:0] readback;
      logic [15:0] junk;
      junk = 16'($urandom);
      csr_transfer(1'b1, pbd_pkg::REG_MIN_SWING, {junk, lo}, readback);
      junk = 16'($urandom);
      csr_transfer(1'b1, pbd_pkg::REG_MAX_SWING, {junk, hi}, readback);
      csr_transfer(1'b0, pbd_pkg::REG_MIN_SWING, '0, readback);
      if (readback[15:0] !== lo)
         note_mismatch("min_swing readback", lo, readback[15:0]);
      csr_transfer(1'b0, pbd_pkg::REG_MAX_SWING, '0, readback);
      if (readback[15:0] !== hi)
         note_mismatch("max_swing readback", hi, readback[15:0]);
      est_min_swing = lo;
      est_max_swing = hi;
   endtask

   // ------------------------------------------------------------------------
   // Result side: check every transfer, then pick the next tready
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : result_check
      beat_result_type got;
      beat_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.beat     = rsp_tdata[0];
            got.ac_value = rsp_tdata[16:1];
            got.dc_level = rsp_tdata[32:17];
            if (pending_results.size() == 0) begin
               $display("%0t ns: unexpected result, expected none, actual %0d/%0d/%0d",
                        $time, got.beat, got.ac_value, got.dc_level);
               error_count++;
            end else begin
               want = pending_results.pop_front();
               if (got.beat !== want.beat)
                  note_mismatch("beat", want.beat, got.beat);
               if (got.ac_value !== want.ac_value)
                  note_mismatch("ac_value", want.ac_value, got.ac_value);
               if (got.dc_level !== want.dc_level)
                  note_mismatch("dc_level", want.dc_level, got.dc_level);
            end
         end
         // stall in bursts
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (!calm && $urandom_range(99) < stall_pct) begin
            stall_left = $urandom_range(13, 0);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Watchdog: any stream transfer counts as progress.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------
   initial begin
      logic [15:0] lo_limit [PhaseTotal];
      logic [15:0] hi_limit [PhaseTotal];
      logic [15:0] low;
      logic [17:0] raw;
      int          p;
      int          n;
      int          r;
      int          kind;
      int          seq_left;
      int          period;
      int          amp;
      int          base;
      int          noise;
      int          step;
      int          wave;
      int          level;

      // estimator starts from the detector's reset state
      est_dc_acc         = '0;
      est_slot           = '0;
      est_prev_ac        = '0;
      est_peak_latched   = 16'sd20;
      est_trough_latched = -16'sd20;
      est_peak_run       = '0;
      est_trough_run     = '0;
      est_rising         = 1'b0;
      est_falling        = 1'b0;
      est_min_swing      = pbd_pkg::MIN_SWING_RESET;
      est_max_swing      = pbd_pkg::MAX_SWING_RESET;
      foreach (est_taps[i])
         est_taps[i] = '0;

      // widest window, narrow, closed window, equal, random, reset defaults
      lo_limit = '{16'd0, 16'd5, 16'hFFFF, 16'd300, 16'd0, 16'd20};
      hi_limit = '{16'hFFFF, 16'd400, 16'd0, 16'd300, 16'd0, 16'd1000};
      lo_limit[4] = 16'($urandom_range(100));
      hi_limit[4] = 16'($urandom_range(5000, 200));

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table under the reset limits
      gap_pct   = 25;
      stall_pct = 25;
      foreach (directed_rows[i])
         send_sample(directed_rows[i].raw, directed_rows[i].typed,
                     directed_rows[i].result);
      flush_results();

      seq_left = 0;
      period   = 20;
      amp      = 0;
      base     = 0;
      noise    = 0;
      step     = 0;
      kind     = 0;
      level    = 0;
      for (p = 0; p < PhaseTotal; p++) begin
         set_swing_limits(lo_limit[p], hi_limit[p]);
         // phase 1 runs without idling, the last phase is the calm stretch
         if (p == 1 || p == PhaseTotal - 1) begin
            gap_pct   = 0;
            stall_pct = 0;
         end else begin
            gap_pct   = $urandom_range(60, 10);
            stall_pct = $urandom_range(60, 10);
         end
         calm = (p == PhaseTotal - 1);

         for (n = 0; n < PhaseItems; n++) begin
            if (seq_left == 0) begin
               // mostly pulse trains; the rest is noise or a flat level
               r = $urandom_range(9);
               kind   = (r < 8) ? 0 : r - 7;
               step   = 0;
               period = $urandom_range(80, 12);
               amp    = ($urandom_range(4) == 0) ? $urandom_range(20000, 600)
                                                 : $urandom_range(600, 5);
               base   = $urandom_range(50000, 15000);
               noise  = ($urandom_range(2) == 0) ? 0 : amp / 8;
               level  = $urandom_range(65535);
               seq_left = (kind == 0) ? $urandom_range(200, 40) :
                          (kind == 1) ? $urandom_range(15, 3) : $urandom_range(30, 5);
            end
            case (kind)
               0: begin
                  // triangle pulse around a base level
                  r = step % period;
                  if (r < period / 2)
                     wave = -amp + (4 * amp * r) / period;
                  else
                     wave = 3 * amp - (4 * amp * r) / period;
                  if (noise > 0)
                     wave = wave + int'($urandom_range(2 * noise)) - noise;
                  low = 16'(base + wave);
               end
               1: low = 16'($urandom);
               default: low = 16'(level);
            endcase
            raw = {2'($urandom), low};
            step++;
            seq_left--;
            send_sample(raw, 1'b0, '0);
         end
         flush_results();
      end

      if (error_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

// ===== pulse_beat_detector.f =====
rtl/pbd_pkg.sv
rtl/pbd_tap_cell.sv
rtl/pbd_tap_chain.sv
rtl/pbd_fir_mac.sv
rtl/pulse_beat_detector.sv
dv/testbench.sv
